FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the frame rate statistics monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define FRSM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition is never true at a rising clock edge outside reset.
`define FRSM_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: sv/frsm_pkg.sv
// Package with the types and constants of the frame rate statistics monitor.
`default_nettype none

package frsm_pkg;

    localparam int DEFAULT_DURATION_WIDTH = 32;
    localparam int DEFAULT_COUNT_WIDTH = 48;

    localparam logic CFG_TIME_SCALE = 1'b0;
    localparam logic CFG_TICKS_PER_SECOND = 1'b1;

    localparam logic KIND_OPEN = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam logic [15:0] TIME_SCALE_RESET = 16'd256;
    localparam logic [31:0] TPS_RESET = 32'd1000000;
    localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;

    localparam int QUOT_WIDTH = 32;
    localparam int TOTAL_WIDTH = 48;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } frsm_div_stat_t;

endpackage

`default_nettype wire

FILE: sv/frame_rate_statistics_monitor.sv
// Top level of the frame rate statistics monitor: sequencer, statistics state and ports.
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  tuser kind, tdata frame_ticks
//   m_        out        m_tvalid/m_tready  tdata all eleven statistics
//   cfg_      in         cfg_valid/ready    cfg_index, cfg_data
//
// An open item goes straight to the output push step; a close item runs through the
// update, rate, second, window, min/max and average steps on the bit-serial divider and
// multiplier, which handle one bit per cycle. Reset is synchronous and clears all
// statistics. A new item is taken while a result waits in the output register; the
// finished result then holds until the output register is free. Configuration writes
// are taken only while no item is in flight and go ahead of a waiting input item.
`default_nettype none

module frame_rate_statistics_monitor #(
    parameter int DURATION_WIDTH = frsm_pkg::DEFAULT_DURATION_WIDTH,
    parameter int COUNT_WIDTH = frsm_pkg::DEFAULT_COUNT_WIDTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // frame_ticks
    input  wire logic [0:0]    s_tuser,   // kind
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // frame_count, frame_rate, rate_last_second, rate_min, rate_max, rate_average,
    // scaled_delta, smoothed_delta, unscaled_elapsed, scaled_elapsed, window_frame_ticks
    output logic [423:0]       m_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);
    import frsm_pkg::*;

    `include "assert_macros.svh"

    localparam int PW = COUNT_WIDTH + 32;
    localparam int NBW = $clog2(PW + 1);
    localparam int DMW = (DURATION_WIDTH < 32) ? DURATION_WIDTH : 32;
    localparam logic [31:0] DMASK = (DMW >= 32) ? 32'hFFFF_FFFF : ((32'd1 << DMW) - 32'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_UPD, S_RATE, S_RATE_W, S_SEC, S_SEC_W, S_WIN, S_WIN_W,
        S_MINMAX, S_AVG_M, S_AVG_MW, S_AVG_D, S_AVG_DW, S_PUSH
    } state_t;

    state_t state_reg;

    logic [15:0]            time_scale_reg;
    logic [31:0]            tps_reg;
    logic [31:0]            d_reg;
    logic [47:0]            prod_reg;
    logic [47:0]            unscaled_total_reg;
    logic [55:0]            scaled_total_reg;
    logic [39:0]            last_scaled_reg;
    logic [39:0]            smooth_reg;
    logic [COUNT_WIDTH-1:0] frames_done_reg;
    logic [COUNT_WIDTH-1:0] frames_at_mark_reg;
    logic [31:0]            current_second_reg;
    logic [31:0]            inst_rate_reg;
    logic [31:0]            window_rate_reg;
    logic [31:0]            low_rate_reg;
    logic [31:0]            high_rate_reg;
    logic [31:0]            window_ticks_reg;
    logic [31:0]            avg_rate_reg;
    logic                   m_tvalid_reg;
    logic [423:0]           m_tdata_reg;

    logic                   div_start;
    logic [PW-1:0]          div_dividend;
    logic [47:0]            div_divisor;
    logic [NBW-1:0]         div_nbits;
    logic [31:0]            div_quot;
    frsm_div_stat_t         div_stat;
    logic                   mul_start;
    logic [PW-1:0]          mul_product;
    logic                   mul_done;

    logic [39:0]            scaled_new;
    logic [31:0]            window_rate_next;

    assign scaled_new = prod_reg[47:8];
    assign window_rate_next = 32'(frames_done_reg - frames_at_mark_reg);

    always_comb begin
        div_start = 1'b0;
        div_dividend = {tps_reg, {(PW-32){1'b0}}};
        div_divisor = 48'(d_reg);
        div_nbits = NBW'(32);
        mul_start = 1'b0;
        unique case (state_reg)
            S_RATE: begin
                div_start = (d_reg != 32'd0);
            end
            S_SEC: begin
                div_start = 1'b1;
                div_dividend = {unscaled_total_reg, {(PW-48){1'b0}}};
                div_divisor = (tps_reg != 32'd0) ? 48'(tps_reg) : 48'd1;
                div_nbits = NBW'(48);
            end
            S_WIN: begin
                div_start = 1'b1;
                div_divisor = 48'(window_rate_reg);
            end
            S_AVG_M: begin
                mul_start = (unscaled_total_reg != 48'd0);
            end
            S_AVG_D: begin
                div_start = 1'b1;
                div_dividend = mul_product;
                div_divisor = unscaled_total_reg;
                div_nbits = NBW'(PW);
            end
            default: begin
            end
        endcase
    end

    frsm_div_serial #(.PW(PW), .VW(TOTAL_WIDTH), .NBW(NBW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .nbits(div_nbits), .quotient(div_quot), .stat(div_stat)
    );

    frsm_mul_serial #(.AW(COUNT_WIDTH), .BW(32), .CNTW(6)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(frames_done_reg),
        .b(tps_reg), .product(mul_product), .done(mul_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            time_scale_reg <= TIME_SCALE_RESET;
            tps_reg <= TPS_RESET;
            unscaled_total_reg <= '0;
            scaled_total_reg <= '0;
            last_scaled_reg <= '0;
            smooth_reg <= '0;
            frames_done_reg <= '0;
            frames_at_mark_reg <= '0;
            current_second_reg <= '0;
            inst_rate_reg <= '0;
            window_rate_reg <= '0;
            low_rate_reg <= ONES32;
            high_rate_reg <= '0;
            window_ticks_reg <= '0;
            avg_rate_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index[0])
                    CFG_TIME_SCALE: time_scale_reg <= cfg_data[15:0];
                    CFG_TICKS_PER_SECOND: tps_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != S_PUSH)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        d_reg <= s_tdata & DMASK;
                        state_reg <= (s_tuser[0] == KIND_CLOSE) ? S_MUL : S_PUSH;
                    end
                end
                S_MUL: begin
                    prod_reg <= d_reg * time_scale_reg;
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    last_scaled_reg <= scaled_new;
                    unscaled_total_reg <= unscaled_total_reg + 48'(d_reg);
                    scaled_total_reg <= scaled_total_reg + 56'(scaled_new);
                    if (scaled_new >= smooth_reg) begin
                        smooth_reg <= smooth_reg + ((scaled_new - smooth_reg) >> 1);
                    end else begin
                        smooth_reg <= smooth_reg - ((smooth_reg - scaled_new) >> 1);
                    end
                    frames_done_reg <= frames_done_reg + COUNT_WIDTH'(1);
                    state_reg <= S_RATE;
                end
                S_RATE: begin
                    state_reg <= (d_reg != 32'd0) ? S_RATE_W : S_SEC;
                end
                S_RATE_W: begin
                    if (div_stat.done) begin
                        inst_rate_reg <= div_quot;
                        state_reg <= S_SEC;
                    end
                end
                S_SEC: begin
                    state_reg <= S_SEC_W;
                end
                S_SEC_W: begin
                    if (div_stat.done) begin
                        if (div_quot != current_second_reg) begin
                            window_rate_reg <= window_rate_next;
                            frames_at_mark_reg <= frames_done_reg;
                            current_second_reg <= div_quot;
                            low_rate_reg <= ONES32;
                            high_rate_reg <= '0;
                            if (window_rate_next != 32'd0) begin
                                state_reg <= S_WIN;
                            end else begin
                                window_ticks_reg <= ONES32;
                                state_reg <= S_MINMAX;
                            end
                        end else begin
                            state_reg <= S_MINMAX;
                        end
                    end
                end
                S_WIN: begin
                    state_reg <= S_WIN_W;
                end
                S_WIN_W: begin
                    if (div_stat.done) begin
                        window_ticks_reg <= div_quot;
                        state_reg <= S_MINMAX;
                    end
                end
                S_MINMAX: begin
                    if (inst_rate_reg < low_rate_reg) begin
                        low_rate_reg <= inst_rate_reg;
                    end
                    if (inst_rate_reg > high_rate_reg) begin
                        high_rate_reg <= inst_rate_reg;
                    end
                    state_reg <= S_AVG_M;
                end
                S_AVG_M: begin
                    if (unscaled_total_reg == 48'd0) begin
                        avg_rate_reg <= ONES32;
                        state_reg <= S_PUSH;
                    end else begin
                        state_reg <= S_AVG_MW;
                    end
                end
                S_AVG_MW: begin
                    if (mul_done) begin
                        state_reg <= S_AVG_D;
                    end
                end
                S_AVG_D: begin
                    state_reg <= S_AVG_DW;
                end
                S_AVG_DW: begin
                    if (div_stat.done) begin
                        avg_rate_reg <= div_stat.ovf ? ONES32 : div_quot;
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {window_ticks_reg, scaled_total_reg,
                            unscaled_total_reg, smooth_reg, last_scaled_reg, avg_rate_reg,
                            high_rate_reg, low_rate_reg, window_rate_reg, inst_rate_reg,
                            48'(frames_done_reg)};
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    `FRSM_ASSERT(a_count_only_in_update, aclk, aresetn, (state_reg != S_UPD) |=> $stable(frames_done_reg), "frame count changed outside the update step")
    `FRSM_NEVER(a_no_start_while_busy, aclk, aresetn, div_start && div_stat.busy, "divider started while busy")
    `FRSM_NEVER(a_idle_div_quiet, aclk, aresetn, s_tready && div_stat.busy, "input ready while divider busy")

endmodule

`default_nettype wire

FILE: sv/frsm_div_serial.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module frsm_div_serial #(
    parameter int PW = 80,
    parameter int VW = 48,
    parameter int NBW = 7
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [PW-1:0]          dividend,
    input  wire logic [VW-1:0]          divisor,
    input  wire logic [NBW-1:0]         nbits,
    output logic [frsm_pkg::QUOT_WIDTH-1:0] quotient,
    output frsm_pkg::frsm_div_stat_t    stat
);
    import frsm_pkg::*;

    logic [PW-1:0]         num_reg;
    logic [VW-1:0]         den_reg;
    logic [VW-1:0]         rem_reg;
    logic [QUOT_WIDTH-1:0] quo_reg;
    logic [NBW-1:0]        cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  ovf_reg;

    logic [VW:0] rem2;
    logic [VW:0] diff;
    logic        ge;

    assign rem2 = {rem_reg, num_reg[PW-1]};
    assign diff = rem2 - {1'b0, den_reg};
    assign ge = rem2 >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg <= dividend;
                den_reg <= divisor;
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= nbits;
                ovf_reg <= 1'b0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                num_reg <= {num_reg[PW-2:0], 1'b0};
                rem_reg <= ge ? diff[VW-1:0] : rem2[VW-1:0];
                quo_reg <= {quo_reg[QUOT_WIDTH-2:0], ge};
                if (ge && (cnt_reg > NBW'(QUOT_WIDTH))) begin
                    ovf_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - NBW'(1);
                if (cnt_reg == NBW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign stat = '{busy: busy_reg, done: done_reg, ovf: ovf_reg};

endmodule

`default_nettype wire

FILE: sv/frsm_mul_serial.sv
// Shift-add multiplier that takes one bit of the second operand per cycle.
`default_nettype none

module frsm_mul_serial #(
    parameter int AW = 48,
    parameter int BW = 32,
    parameter int CNTW = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [AW-1:0]     a,
    input  wire logic [BW-1:0]     b,
    output logic [AW+BW-1:0]       product,
    output logic                   done
);
    logic [AW+BW-1:0] acc_reg;
    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg <= '0;
                a_reg <= a;
                b_reg <= b;
                cnt_reg <= CNTW'(BW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= {acc_reg[AW+BW-2:0], 1'b0}
                    + (b_reg[BW-1] ? (AW+BW)'(a_reg) : '0);
                b_reg <= {b_reg[BW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign product = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire
